// ===== hw/rtl/ant_pkg.sv =====
// Shared types, sizes and codes for the active note table.
`default_nettype none

package ant_pkg;

  // Table size and the index and count widths derived from it.
  localparam int unsigned MaxActive = 32;
  localparam int unsigned IdxW      = $clog2(MaxActive);
  localparam int unsigned CntW      = $clog2(MaxActive + 1);

  // Command codes carried on the slave-side tuser.
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_EXPIRE  = 2'd1,
    CMD_ALL_OFF = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_e;

  // Result kinds carried on the master-side tuser.
  typedef enum logic [1:0] {
    KIND_ON   = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_DROP = 2'd3
  } kind_e;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  // One table entry.
  typedef struct packed {
    logic [31:0] end_tick;
    logic [15:0] note_id;
    logic [7:0]  track;
  } entry_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic            shift;
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ant_cell.sv =====
// One cell of the note chain: holds a single entry and takes its neighbor's on a shift.
`default_nettype none

module ant_cell
  import ant_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic [IdxW-1:0] idx_i,
  input  cell_ctl_t            ctl_i,
  input  entry_t               wr_data_i,
  input  entry_t               next_i,
  output entry_t               data_o
);

  entry_t data_q;
  entry_t data_d;

  // A write aimed at this cell wins over the shift from the neighbor.
  always_comb begin
    data_d = data_q;
    if (ctl_i.wr_en && (ctl_i.wr_idx == idx_i)) begin
      data_d = wr_data_i;
    end else if (ctl_i.shift) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ant_ctrl.sv =====
// Command sequencer: walks the head of the cell chain and drives the result register.
`default_nettype none

module ant_ctrl
  import ant_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  entry_t           head_i,
  output cell_ctl_t        ctl_o,
  output entry_t           wr_data_o
);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] keep_q, keep_d;
  logic [IdxW-1:0] wptr_q, wptr_d;
  cmd_e            mode_q, mode_d;
  logic [31:0]     key_q, key_d;
  logic            pend_valid_q, pend_valid_d;
  entry_t          pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  kind_e           out_kind_q, out_kind_d;
  logic [7:0]      out_track_q, out_track_d;
  logic [15:0]     out_note_q, out_note_d;
  logic            out_last_q, out_last_d;

  entry_t          in_entry;
  cmd_e            in_cmd;
  logic [31:0]     in_now;
  logic            accept;
  logic            out_free;
  logic            gone;
  logic            step;

  // Unpack the request.
  assign in_entry.track    = s_axis_tdata[7:0];
  assign in_entry.note_id  = s_axis_tdata[23:8];
  assign in_entry.end_tick = s_axis_tdata[55:24];
  assign in_now            = s_axis_tdata[87:56];
  assign in_cmd            = cmd_e'(s_axis_tuser);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Removal test on the entry at the head of the chain.
  always_comb begin
    case (mode_q)
      CMD_EXPIRE:  gone = (head_i.end_tick <= key_q);
      CMD_ALL_OFF: gone = 1'b1;
      CMD_RELEASE: gone = (head_i.track == key_q[7:0]);
      default:     gone = 1'b0;
    endcase
  end

  // A removed note can only advance when the pending one has room to leave.
  assign step = (state_q == ST_SWEEP) && (!gone || !pend_valid_q || out_free);

  // Next-state logic for the sequencer, the pending note and the result register.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    keep_d       = keep_q;
    wptr_d       = wptr_q;
    mode_d       = mode_q;
    key_d        = key_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_kind_d   = out_kind_q;
    out_track_d  = out_track_q;
    out_note_d   = out_note_q;
    out_last_d   = out_last_q;
    ctl_o        = '0;
    wr_data_o    = in_entry;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_START) begin
            out_valid_d = 1'b1;
            out_track_d = in_entry.track;
            out_note_d  = in_entry.note_id;
            out_last_d  = 1'b1;
            if (count_q < CntW'(MaxActive)) begin
              ctl_o.wr_en  = 1'b1;
              ctl_o.wr_idx = count_q[IdxW-1:0];
              count_d      = count_q + CntW'(1);
              out_kind_d   = KIND_ON;
            end else begin
              out_kind_d = KIND_DROP;
            end
          end else begin
            mode_d       = in_cmd;
            key_d        = (in_cmd == CMD_RELEASE) ? {24'd0, in_entry.track} : in_now;
            rem_d        = count_q;
            keep_d       = '0;
            wptr_d       = IdxW'(count_q - CntW'(1));
            pend_valid_d = 1'b0;
            state_d      = (count_q == '0) ? ST_FLUSH : ST_SWEEP;
          end
        end
      end

      ST_SWEEP: begin
        if (step) begin
          // Every cell moves one place toward the head; a kept note is
          // written back just behind the notes still to be examined.
          ctl_o.shift = 1'b1;
          wr_data_o   = head_i;
          rem_d       = rem_q - CntW'(1);
          if (gone) begin
            wptr_d       = wptr_q - IdxW'(1);
            pend_valid_d = 1'b1;
            pend_d       = head_i;
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = KIND_OFF;
              out_track_d = pend_q.track;
              out_note_d  = pend_q.note_id;
              out_last_d  = 1'b0;
            end
          end else begin
            ctl_o.wr_en  = 1'b1;
            ctl_o.wr_idx = wptr_q;
            keep_d       = keep_q + CntW'(1);
          end
          if (rem_q == CntW'(1)) begin
            state_d = ST_FLUSH;
          end
        end
      end

      ST_FLUSH: begin
        // The last removed note closes the command, or a done item if none.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          if (pend_valid_q) begin
            out_kind_d  = KIND_OFF;
            out_track_d = pend_q.track;
            out_note_d  = pend_q.note_id;
          end else begin
            out_kind_d  = KIND_DONE;
            out_track_d = '0;
            out_note_d  = '0;
          end
          pend_valid_d = 1'b0;
          count_d      = keep_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      rem_q        <= '0;
      keep_q       <= '0;
      wptr_q       <= '0;
      mode_q       <= CMD_START;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rem_q        <= rem_d;
      keep_q       <= keep_d;
      wptr_q       <= wptr_d;
      mode_q       <= mode_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    pend_q      <= pend_d;
    out_kind_q  <= out_kind_d;
    out_track_q <= out_track_d;
    out_note_q  <= out_note_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_note_q, out_track_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/active_note_table_core.sv =====
// Top level of the active note table: sequencer plus a chain of entry cells.
//
// Requests enter on the slave-side stream: tuser holds the command, tdata the
// track, note identity, end tick and expire tick. Results leave on the
// master-side stream: tuser holds the kind, tdata the track and note, and
// tlast marks the final result of each request.
// A start request is taken and its note-on or dropped result is valid the
// cycle after. Expire, all-off and release walk the table through the head
// of the cell chain, one entry per cycle while the receiver keeps up, and
// keep the table order of the notes that stay.
// A new request is taken only once the previous one has finished and the
// result register is free or being emptied. When the receiver stalls, the
// walk halts at a removed note until the earlier removed note's result can leave.
// Reset empties the table and clears the result register; the entry cells
// themselves are not cleared, since only stored entries are ever read.
`default_nettype none

module active_note_table_core
  import ant_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: track[7:0], note_id[23:8], note_end[55:24], now_tick[87:56]
  input  wire logic [87:0] s_axis_tdata,
  // tuser: command[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: out_track[7:0], out_note[23:8]
  output logic [23:0]      m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  cell_ctl_t ctl;
  entry_t    wr_data;
  entry_t    cell_data [MaxActive];

  // Sequencer and result register.
  ant_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .head_i        (cell_data[0]),
    .ctl_o         (ctl),
    .wr_data_o     (wr_data)
  );

  // Chain of cells; each takes its upper neighbor's entry on a shift.
  for (genvar i = 0; i < MaxActive; i++) begin : g_cell
    entry_t next_entry;
    if (i == MaxActive - 1) begin : g_tail
      assign next_entry = cell_data[i];
    end else begin : g_body
      assign next_entry = cell_data[i+1];
    end

    ant_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (IdxW'(i)),
      .ctl_i     (ctl),
      .wr_data_i (wr_data),
      .next_i    (next_entry),
      .data_o    (cell_data[i])
    );
  end

endmodule

`default_nettype wire
